[sv/ipid_pkg.sv]
// ----------------------------------------------------------------------------
// ipid_pkg
// Shared types, constants and helpers of the multichannel incremental PID unit.
// ----------------------------------------------------------------------------
package ipid_pkg;

  // Default configuration
  localparam int CHANNELS_DEF  = 4;
  localparam int FRAC_BITS_DEF = 16;

  // Field and port widths
  localparam int DATA_W      = 32;
  localparam int CH_FIELD_W  = 2;
  localparam int IN_TDATA_W  = 6 * DATA_W;
  localparam int IN_TUSER_W  = 1 + CH_FIELD_W;
  localparam int OUT_TDATA_W = DATA_W;

  // Reset values in whole units, scaled by 2^FRAC_BITS in the unit
  localparam int KP_RESET_UNITS       = 1;
  localparam int SETPOINT_RESET_UNITS = 5;
  localparam int OUTPUT_RESET_UNITS   = 2;

  // Item kinds
  typedef enum logic {
    OP_STEP = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  // Per-channel coefficient word
  typedef struct packed {
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] kd;
    logic signed [DATA_W-1:0] ki;
    logic signed [DATA_W-1:0] kp;
  } gain_word_t;

  // Per-channel history word
  typedef struct packed {
    logic signed [DATA_W-1:0] out_last;
    logic signed [DATA_W-1:0] err_prev2;
    logic signed [DATA_W-1:0] err_prev;
  } hist_word_t;

  // Saturate a wide signed value to 32 bits signed
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

endpackage

[sv/incremental_pid_multichannel_unit.sv]
// A step item's result is registered in stages 1, 2 and 3 and then output.
// Throughput: one item per cycle over different channels while the output is
// not stalled; a step on the same channel waits until the previous one has
// written the history memory back. Load items never stall.
// Reset: per-channel valid bits clear, so every channel reads its default
// gains, setpoint and history until first written; pipeline and output empty.
// ----------------------------------------------------------------------------
// incremental_pid_multichannel_unit
// Multichannel velocity-form PID: coefficients and error/output history live
// in two registered-read memories; history has a 3-stage read-modify-write.
// ----------------------------------------------------------------------------
module incremental_pid_multichannel_unit #(
  parameter int CHANNELS  = ipid_pkg::CHANNELS_DEF,
  parameter int FRAC_BITS = ipid_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input item channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: measured, out_limit, new_kp, new_ki, new_kd, new_setpoint
  input  logic [ipid_pkg::IN_TDATA_W-1:0]   in_tdata,
  // tuser: op, channel[1:0]
  input  logic [ipid_pkg::IN_TUSER_W-1:0]   in_tuser,
  // result item channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata: drive
  output logic [ipid_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // tuser: clamped
  output logic                              out_tuser
);

  localparam int DW     = ipid_pkg::DATA_W;
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TERM_W = 64 - FRAC_BITS;
  localparam int SUM_W  = TERM_W + 3;

  localparam logic signed [DW-1:0] KP_RST =
    DW'(64'(ipid_pkg::KP_RESET_UNITS) << FRAC_BITS);
  localparam logic signed [DW-1:0] SETPOINT_RST =
    DW'(64'(ipid_pkg::SETPOINT_RESET_UNITS) << FRAC_BITS);
  localparam logic signed [DW-1:0] OUTPUT_RST =
    DW'(64'(ipid_pkg::OUTPUT_RESET_UNITS) << FRAC_BITS);

  // --------------------------------------------------------------------------
  // Input field unpacking
  // --------------------------------------------------------------------------
  ipid_pkg::op_t                  in_op;
  logic [ipid_pkg::CH_FIELD_W-1:0] in_channel;
  logic [CH_W+1:0]                in_ch_ext;
  logic [CH_W-1:0]                in_idx;
  logic                           in_ch_ok;
  logic signed [DW-1:0]           in_measured;
  logic signed [DW-1:0]           in_limit;
  ipid_pkg::gain_word_t           in_gain;

  assign in_op       = ipid_pkg::op_t'(in_tuser[0]);
  assign in_channel  = in_tuser[2:1];
  assign in_ch_ext   = (CH_W+2)'(in_channel);
  assign in_idx      = in_ch_ext[CH_W-1:0];
  assign in_ch_ok    = (32'(in_channel) < 32'(CHANNELS));
  assign in_measured = in_tdata[DW-1:0];
  assign in_limit    = in_tdata[2*DW-1:DW];
  assign in_gain     = '{setpoint: in_tdata[6*DW-1:5*DW], kd: in_tdata[5*DW-1:4*DW],
                         ki: in_tdata[4*DW-1:3*DW], kp: in_tdata[3*DW-1:2*DW]};

  // --------------------------------------------------------------------------
  // Pipeline state
  // --------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic [CHANNELS-1:0] gain_vld_r, hist_vld_r;

  // stage 1: memory read data plus item fields
  logic [CH_W-1:0]          s1_idx_r;
  logic signed [DW-1:0]     s1_meas_r, s1_limit_r;
  logic                     s1_gvld_r, s1_hvld_r;
  ipid_pkg::gain_word_t     gain_rd_r;
  ipid_pkg::hist_word_t     hist_rd_r;

  // stage 2: errors and differences
  logic [CH_W-1:0]          s2_idx_r;
  logic signed [DW-1:0]     s2_kp_r, s2_ki_r, s2_kd_r;
  logic signed [DW-1:0]     s2_err_r, s2_d1_r, s2_d2_r, s2_e1_r, s2_out_r, s2_limit_r;

  // stage 3: scaled products
  logic [CH_W-1:0]          s3_idx_r;
  logic signed [TERM_W-1:0] s3_tp_r, s3_ti_r, s3_td_r;
  logic signed [DW-1:0]     s3_err_r, s3_e1_r, s3_out_r, s3_limit_r;

  // output register
  logic [DW-1:0]            out_drive_r;
  logic                     out_clamp_r;

  // --------------------------------------------------------------------------
  // Flow control and same-channel interlock
  // --------------------------------------------------------------------------
  logic s3_go, s3_free, s2_go, s2_free, s1_go, s1_free;
  logic hazard, in_fire, step_fire, load_fire;

  assign s3_go   = s3_v_r && (!out_v_r || out_tready);
  assign s3_free = !s3_v_r || s3_go;
  assign s2_go   = s2_v_r && s3_free;
  assign s2_free = !s2_v_r || s2_go;
  assign s1_go   = s1_v_r && s2_free;
  assign s1_free = !s1_v_r || s1_go;

  // a step may not read history that an earlier step has yet to write back
  assign hazard = (s1_v_r && (s1_idx_r == in_idx)) ||
                  (s2_v_r && (s2_idx_r == in_idx)) ||
                  (s3_v_r && (s3_idx_r == in_idx));

  assign in_tready = (in_op == ipid_pkg::OP_LOAD) || (s1_free && !hazard);
  assign in_fire   = in_tvalid && in_tready;
  assign step_fire = in_fire && (in_op == ipid_pkg::OP_STEP) && in_ch_ok;
  assign load_fire = in_fire && (in_op == ipid_pkg::OP_LOAD) && in_ch_ok;

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  ipid_pkg::gain_word_t gain_mem [CHANNELS];
  ipid_pkg::hist_word_t hist_mem [CHANNELS];
  ipid_pkg::hist_word_t hist_wr;

  always_ff @(posedge clk) begin
    if (load_fire) begin
      gain_mem[in_idx] <= in_gain;
    end
    if (step_fire) begin
      gain_rd_r <= gain_mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (s3_go) begin
      hist_mem[s3_idx_r] <= hist_wr;
    end
    if (step_fire) begin
      hist_rd_r <= hist_mem[in_idx];
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      s3_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      gain_vld_r <= '0;
      hist_vld_r <= '0;
    end else begin
      if (s1_free) s1_v_r <= step_fire;
      if (s2_free) s2_v_r <= s1_go;
      if (s3_free) s3_v_r <= s2_go;
      if (s3_go) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (load_fire) gain_vld_r[in_idx] <= 1'b1;
      if (s3_go)     hist_vld_r[s3_idx_r] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: defaults for unwritten channels, error and differences
  // --------------------------------------------------------------------------
  ipid_pkg::gain_word_t s1_gain;
  ipid_pkg::hist_word_t s1_hist;
  logic signed [DW-1:0] s1_err, s1_d1, s1_d2;

  always_comb begin
    s1_gain = s1_gvld_r ? gain_rd_r :
              ipid_pkg::gain_word_t'{setpoint: SETPOINT_RST, kd: '0, ki: '0, kp: KP_RST};
    s1_hist = s1_hvld_r ? hist_rd_r :
              ipid_pkg::hist_word_t'{out_last: OUTPUT_RST, err_prev2: '0, err_prev: '0};
    s1_err  = ipid_pkg::sat32(64'(s1_gain.setpoint) - 64'(s1_meas_r));
    s1_d1   = ipid_pkg::sat32(64'(s1_err) - 64'(s1_hist.err_prev));
    s1_d2   = ipid_pkg::sat32(64'(s1_err) + 64'(s1_hist.err_prev2)
                              - (64'(s1_hist.err_prev) <<< 1));
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      s1_idx_r   <= in_idx;
      s1_meas_r  <= in_measured;
      s1_limit_r <= in_limit;
      s1_gvld_r  <= gain_vld_r[in_idx];
      s1_hvld_r  <= hist_vld_r[in_idx];
    end
    if (s1_go) begin
      s2_idx_r   <= s1_idx_r;
      s2_kp_r    <= s1_gain.kp;
      s2_ki_r    <= s1_gain.ki;
      s2_kd_r    <= s1_gain.kd;
      s2_err_r   <= s1_err;
      s2_d1_r    <= s1_d1;
      s2_d2_r    <= s1_d2;
      s2_e1_r    <= s1_hist.err_prev;
      s2_out_r   <= s1_hist.out_last;
      s2_limit_r <= s1_limit_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: three gain products, floor-shifted by the fraction width
  // --------------------------------------------------------------------------
  logic signed [63:0] prod_p, prod_i, prod_d;

  assign prod_p = 64'(s2_kp_r) * 64'(s2_d1_r);
  assign prod_i = 64'(s2_ki_r) * 64'(s2_err_r);
  assign prod_d = 64'(s2_kd_r) * 64'(s2_d2_r);

  always_ff @(posedge clk) begin
    if (s2_go) begin
      s3_idx_r   <= s2_idx_r;
      s3_tp_r    <= prod_p[63:FRAC_BITS];
      s3_ti_r    <= prod_i[63:FRAC_BITS];
      s3_td_r    <= prod_d[63:FRAC_BITS];
      s3_err_r   <= s2_err_r;
      s3_e1_r    <= s2_e1_r;
      s3_out_r   <= s2_out_r;
      s3_limit_r <= s2_limit_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: accumulate, saturate, clamp, write history back
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0] s3_sum;
  logic signed [DW-1:0]    s3_sat, s3_drive, s3_err_wb;
  logic                    s3_clamp;

  always_comb begin
    s3_sum    = SUM_W'(s3_out_r) + SUM_W'(s3_tp_r) + SUM_W'(s3_ti_r) + SUM_W'(s3_td_r);
    s3_sat    = ipid_pkg::sat32(64'(s3_sum));
    s3_clamp  = (s3_sat >= s3_limit_r);
    s3_drive  = s3_clamp ? s3_limit_r : s3_sat;
    s3_err_wb = s3_clamp ? '0 : s3_err_r;
    hist_wr   = '{out_last: s3_drive, err_prev2: s3_e1_r, err_prev: s3_err_wb};
  end

  always_ff @(posedge clk) begin
    if (s3_go) begin
      out_drive_r <= s3_drive;
      out_clamp_r <= s3_clamp;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_drive_r;
  assign out_tuser  = out_clamp_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // no two steps of the same channel in flight at once
  a_one_per_channel: assert property (@(posedge clk) disable iff (!rst_n)
    !((s1_v_r && s2_v_r && (s1_idx_r == s2_idx_r)) ||
      (s1_v_r && s3_v_r && (s1_idx_r == s3_idx_r)) ||
      (s2_v_r && s3_v_r && (s2_idx_r == s3_idx_r))))
    else $error("two steps of one channel in flight");

  // a clamped result carries exactly the limit
  a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_go && s3_clamp) |=> (out_tuser && (out_tdata == $past(s3_limit_r))))
    else $error("clamped drive differs from limit");

  // an accepted step enters stage 1 with its channel
  a_step_enters: assert property (@(posedge clk) disable iff (!rst_n)
    step_fire |=> (s1_v_r && (s1_idx_r == $past(in_idx))))
    else $error("accepted step lost before stage 1");

endmodule

[tb/incremental_pid_multichannel_unit_tb.sv]
// ----------------------------------------------------------------------------
// incremental_pid_multichannel_unit_tb
// Self-checking bench for the four-channel incremental PID unit. A directed
// table covers the reset values, the clamp-at-limit cases and extreme gains.
// Random step and load items follow under several idle/stall mixes. Every
// result item is checked against its typed table value or a Q16.16 bench model.
// ----------------------------------------------------------------------------
module incremental_pid_multichannel_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH        = ipid_pkg::CHANNELS_DEF;
  localparam int FB         = ipid_pkg::FRAC_BITS_DEF;
  localparam int ONE        = 1 << FB;
  localparam int PHASE_LEN  = 382;
  localparam int QUIET_MAX  = 4000;
  localparam int DRAIN_CYC  = 8;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef struct {
    ipid_pkg::op_t      op;
    logic [1:0]         ch;
    logic signed [31:0] meas;
    logic signed [31:0] lim;
    logic signed [31:0] kp;
    logic signed [31:0] ki;
    logic signed [31:0] kd;
    logic signed [31:0] sp;
    bit                 typed;
    logic signed [31:0] want_drive;
    bit                 want_clamp;
  } pid_item_t;

  typedef struct {
    logic signed [31:0] drive;
    bit                 clamped;
  } drive_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [ipid_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic [ipid_pkg::IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [ipid_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;

  // channel model state
  logic signed [31:0] kp_m [NCH];
  logic signed [31:0] ki_m [NCH];
  logic signed [31:0] kd_m [NCH];
  logic signed [31:0] sp_m [NCH];
  logic signed [31:0] e1_m [NCH];
  logic signed [31:0] e2_m [NCH];
  logic signed [31:0] y_m  [NCH];

  drive_word_t drive_expected [$];
  pid_item_t   dir_tab [$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles = 0;

  incremental_pid_multichannel_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // saturate to signed 32 bits
  function automatic logic signed [31:0] clip_s32(input longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return v[31:0];
  endfunction

  // Q16.16 product, low bits dropped toward minus infinity
  function automatic longint fx_prod(input logic signed [31:0] a,
                                     input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> FB;
  endfunction

  // one control step of a channel; updates the channel model
  function automatic drive_word_t next_drive(input logic [1:0] ch,
                                             input logic signed [31:0] meas,
                                             input logic signed [31:0] lim);
    logic signed [31:0] err, d1, d2;
    longint      sum;
    drive_word_t r;
    err = clip_s32(longint'(sp_m[ch]) - longint'(meas));
    d1  = clip_s32(longint'(err) - longint'(e1_m[ch]));
    d2  = clip_s32(longint'(err) + longint'(e2_m[ch]) - 2 * longint'(e1_m[ch]));
    sum = longint'(y_m[ch]) + fx_prod(kp_m[ch], d1) + fx_prod(ki_m[ch], err)
        + fx_prod(kd_m[ch], d2);
    r.drive   = clip_s32(sum);
    r.clamped = 1'b0;
    if (r.drive >= lim) begin
      r.drive   = lim;
      r.clamped = 1'b1;
      err       = '0;
    end
    e2_m[ch] = e1_m[ch];
    e1_m[ch] = err;
    y_m[ch]  = r.drive;
    return r;
  endfunction

  function automatic pid_item_t row(input ipid_pkg::op_t op, input logic [1:0] ch,
                                    input logic signed [31:0] meas, lim,
                                    input logic signed [31:0] kp, ki, kd, sp,
                                    input bit typed = 1'b0,
                                    input logic signed [31:0] wd = '0,
                                    input bit wc = 1'b0);
    pid_item_t it;
    it.op = op; it.ch = ch; it.meas = meas; it.lim = lim;
    it.kp = kp; it.ki = ki; it.kd = kd; it.sp = sp;
    it.typed = typed; it.want_drive = wd; it.want_clamp = wc;
    return it;
  endfunction

  // uniform value within +/- units
  function automatic logic signed [31:0] near(input int units);
    return int'($urandom_range(0, 2 * units * ONE)) - units * ONE;
  endfunction

  // corner values mixed with fully random words
  function automatic logic signed [31:0] wild();
    case ($urandom_range(0, 7))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic pid_item_t rand_item();
    pid_item_t it;
    int        pick;
    it = row(ipid_pkg::OP_STEP, 2'($urandom_range(0, NCH - 1)), $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(99) < 15) begin
      it.op = ipid_pkg::OP_LOAD;
      pick = $urandom_range(99);
      if (pick < 60) begin
        it.kp = near(2); it.ki = near(1); it.kd = near(1); it.sp = near(50);
      end else if (pick < 85) begin
        it.kp = wild(); it.ki = wild(); it.kd = wild();
        it.sp = ($urandom_range(1)) ? near(50) : wild();
      end
    end else begin
      pick = $urandom_range(99);
      if (pick < 70) it.meas = sp_m[it.ch] + near(8);
      else if (pick < 85) it.meas = wild();
      pick = $urandom_range(99);
      if (pick < 60) it.lim = int'($urandom_range(0, 200 * ONE));
      else if (pick < 85) it.lim = y_m[it.ch] + near(4);
      else it.lim = wild();
    end
    return it;
  endfunction

  // drive one item and update the model on its accept edge
  task automatic send_item(input pid_item_t it);
    drive_word_t r;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {it.sp, it.kd, it.ki, it.kp, it.lim, it.meas};
    in_tuser  <= {it.ch, it.op};
    do @(posedge clk); while (!in_tready);
    if (it.op == ipid_pkg::OP_LOAD) begin
      kp_m[it.ch] = it.kp;
      ki_m[it.ch] = it.ki;
      kd_m[it.ch] = it.kd;
      sp_m[it.ch] = it.sp;
    end else begin
      r = next_drive(it.ch, it.meas, it.lim);
      if (it.typed) begin
        r.drive   = it.want_drive;
        r.clamped = it.want_clamp;
      end
      drive_expected.push_back(r);
    end
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    drive_word_t r;
    if (rst_n && out_tvalid && out_tready) begin
      if (drive_expected.size() == 0) begin
        $error("unexpected result item: drive %0d clamped %0b",
               $signed(out_tdata), out_tuser);
        mismatches++;
      end else begin
        r = drive_expected.pop_front();
        if (out_tdata !== r.drive) begin
          $error("drive: expected %0d, got %0d", r.drive, $signed(out_tdata));
          mismatches++;
        end
        if (out_tuser !== r.clamped) begin
          $error("clamped: expected %0b, got %0b", r.clamped, out_tuser);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int idle_mix [4][2];
    idle_mix = '{'{0, 0}, '{52, 0}, '{0, 52}, '{7, 7}};

    for (int c = 0; c < NCH; c++) begin
      kp_m[c] = ONE;
      ki_m[c] = '0;
      kd_m[c] = '0;
      sp_m[c] = 5 * ONE;
      e1_m[c] = '0;
      e2_m[c] = '0;
      y_m[c]  = 2 * ONE;
    end

    // directed: reset values and clamp corners first, on fresh channels
    dir_tab.push_back(row(ipid_pkg::OP_STEP, 0, 5 * ONE, Q_MAX, 0, 0, 0, 0, 1, 2 * ONE, 0));
    // drive equal to limit still clamps
    dir_tab.push_back(row(ipid_pkg::OP_STEP, 1, 5 * ONE, 2 * ONE, 0, 0, 0, 0, 1, 2 * ONE, 1));
    // error saturates high, sum saturates, limit at max
    dir_tab.push_back(row(ipid_pkg::OP_STEP, 2, Q_MIN, Q_MAX, 0, 0, 0, 0, 1, Q_MAX, 1));
    // most negative limit always clamps
    dir_tab.push_back(row(ipid_pkg::OP_STEP, 3, 0, Q_MIN, 0, 0, 0, 0, 1, Q_MIN, 1));
    dir_tab.push_back(row(ipid_pkg::OP_LOAD, 0, 0, 0, ONE / 2, ONE / 4, ONE / 8, 10 * ONE));
    dir_tab.push_back(row(ipid_pkg::OP_STEP, 0, 3 * ONE, Q_MAX, 0, 0, 0, 0));
    dir_tab.push_back(row(ipid_pkg::OP_STEP, 0, 9 * ONE / 2, Q_MAX, 0, 0, 0, 0));
    dir_tab.push_back(row(ipid_pkg::OP_STEP, 0, 12 * ONE, Q_MAX, 0, 0, 0, 0));
    // negative limit
    dir_tab.push_back(row(ipid_pkg::OP_STEP, 0, 9 * ONE, -ONE, 0, 0, 0, 0));
    dir_tab.push_back(row(ipid_pkg::OP_LOAD, 1, 0, 0, Q_MAX, Q_MIN, Q_MAX, Q_MAX));
    dir_tab.push_back(row(ipid_pkg::OP_STEP, 1, Q_MIN, Q_MAX, 0, 0, 0, 0));
    dir_tab.push_back(row(ipid_pkg::OP_STEP, 1, Q_MAX, Q_MAX, 0, 0, 0, 0));
    dir_tab.push_back(row(ipid_pkg::OP_STEP, 1, 0, Q_MAX, 0, 0, 0, 0));
    dir_tab.push_back(row(ipid_pkg::OP_LOAD, 2, 0, 0, Q_MIN, Q_MAX, Q_MIN, Q_MIN));
    dir_tab.push_back(row(ipid_pkg::OP_STEP, 2, Q_MAX, Q_MAX, 0, 0, 0, 0));
    dir_tab.push_back(row(ipid_pkg::OP_STEP, 2, 0, 0, 0, 0, 0, 0));
    // all-ones words everywhere, unused step fields included
    dir_tab.push_back(row(ipid_pkg::OP_LOAD, 3, -1, -1, -1, -1, -1, -1));
    dir_tab.push_back(row(ipid_pkg::OP_STEP, 3, -1, Q_MAX, -1, -1, -1, -1));
    dir_tab.push_back(row(ipid_pkg::OP_STEP, 3, 32'sh5555_5555, 32'shAAAA_AAAA,
                          0, 0, 0, 0));
    dir_tab.push_back(row(ipid_pkg::OP_LOAD, 3, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(ipid_pkg::OP_STEP, 3, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(ipid_pkg::OP_STEP, 3, Q_MIN, Q_MAX, 0, 0, 0, 0));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_item(dir_tab[i]);

    // random items under each idle/stall mix
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_mix[p][0];
      recv_stall_pct = idle_mix[p][1];
      repeat (PHASE_LEN) send_item(rand_item());
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    // drain, then keep checking to catch stray results
    while (drive_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
